// ===== src/huffman_code_bit_packer_top_defines.svh =====
// Assertion macros for the Huffman code bit packer.
// Included by the RTL file that carries the concurrent checks; no other dependencies.
`ifndef HUFFMAN_CODE_BIT_PACKER_TOP_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked while out of reset.
`define HCBP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked while out of reset.
`define HCBP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define HCBP_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define HCBP_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== src/hcbp_pkg.sv =====
// Shared types and constants for the Huffman code bit packer.
// No dependencies.
`default_nettype none

package hcbp_pkg;

   localparam int CMD_W     = 2;
   localparam int SYM_W     = 8;
   localparam int CODE_IN_W = 32;
   localparam int LEN_W     = 6;
   localparam int BYTE_BITS = 8;
   localparam int PEND_W    = 3;

   typedef logic [CMD_W-1:0] cmd_type;

   localparam cmd_type CMD_LOAD   = 2'd0;
   localparam cmd_type CMD_ENCODE = 2'd1;
   localparam cmd_type CMD_FLUSH  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_ALIGN,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

// ===== src/huffman_code_bit_packer_top.sv =====
// Huffman code bit packer: codeword table in a synchronous RAM, bit packing, byte output.
// Depends on hcbp_pkg and huffman_code_bit_packer_top_defines.svh.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+------------------------------------------------
//   req     | in  | req_valid/req_stall| command, symbol, codeword, codeword_length
//   rsp     | out | rsp_valid/rsp_stall| out_byte, last_of_run
//
// Load: one table write. Encode, for n output bytes (0..4):
// table read, merge with pending bits, left-align, then one byte per beat.
// Flush: emits n bytes, n being 0 or 1. Only one item is in flight at a time.
// Reset clears the pending bits and the control state; the table is not cleared.
// A stalled output beat holds its byte; the input side stalls until the item is done.
`default_nettype none

module huffman_code_bit_packer_top #(
   parameter int SYMBOL_COUNT  = 256,
   parameter int MAX_CODE_BITS = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire logic [hcbp_pkg::CMD_W-1:0]        req_command,
   input  wire logic [hcbp_pkg::SYM_W-1:0]        req_symbol,
   input  wire logic [hcbp_pkg::CODE_IN_W-1:0]    req_codeword,
   input  wire logic [hcbp_pkg::LEN_W-1:0]        req_codeword_length,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      logic [hcbp_pkg::BYTE_BITS-1:0]    rsp_out_byte,
   output      logic                              rsp_last_of_run
);
   import hcbp_pkg::*;

`include "huffman_code_bit_packer_top_defines.svh"

   localparam int LEN_CAP   = (MAX_CODE_BITS < CODE_IN_W) ? MAX_CODE_BITS : CODE_IN_W;
   localparam int CODE_W    = LEN_CAP;
   localparam int WORD_W    = LEN_CAP + BYTE_BITS;
   localparam int TOT_W     = $clog2(WORD_W + 1);
   localparam int MAX_BYTES = WORD_W / BYTE_BITS;
   localparam int CNT_W     = $clog2(MAX_BYTES + 1);
   localparam int IDX_W     = $clog2(SYMBOL_COUNT);
   localparam int ENT_W     = LEN_W + CODE_W;

   state_type               state_ff, state_in;
   logic                    req_fire, rsp_fire, sym_ok;
   logic [IDX_W-1:0]        tbl_idx;
   logic [LEN_W-1:0]        len_sat;

   // Table RAM: {length, codeword}
   logic [ENT_W-1:0]        table_mem [SYMBOL_COUNT];
   logic [ENT_W-1:0]        rd_ff;

   logic [BYTE_BITS-1:0]    partial_ff, partial_in;
   logic [PEND_W-1:0]       pend_ff;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [WORD_W-1:0]       value_ff, value_in;
   logic [TOT_W-1:0]        total_ff, total_in;
   logic [WORD_W-1:0]       word_ff, word_in, flush_word;

   logic [LEN_W-1:0]        rd_len;
   logic [CODE_W-1:0]       rd_code, code_mask;
   logic [BYTE_BITS-1:0]    part_mask, flush_byte;

   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid && !rsp_stall;
   assign sym_ok   = {1'b0, req_symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
   assign tbl_idx  = req_symbol[IDX_W-1:0];
   assign len_sat  = (req_codeword_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP)
                                                             : req_codeword_length;

   always_ff @(posedge clock) begin
      if (req_fire && req_command == CMD_LOAD && sym_ok) begin
         table_mem[tbl_idx] <= {len_sat, req_codeword[CODE_W-1:0]};
      end
      if (req_fire && req_command == CMD_ENCODE && sym_ok) begin
         rd_ff <= table_mem[tbl_idx];
      end
   end

   // Merge pending bits with the looked-up codeword, right-aligned.
   always_comb begin
      rd_len    = rd_ff[ENT_W-1 -: LEN_W];
      rd_code   = rd_ff[CODE_W-1:0];
      code_mask = ~({CODE_W{1'b1}} << rd_len);
      part_mask = ~({BYTE_BITS{1'b1}} << pend_ff);
      value_in  = (WORD_W'(partial_ff & part_mask) << rd_len) | WORD_W'(rd_code & code_mask);
      total_in  = TOT_W'(pend_ff) + TOT_W'(rd_len);
   end

   // Left-align so the earliest bit sits in the top byte; leftover bits stay pending.
   always_comb begin
      word_in    = value_ff << (TOT_W'(WORD_W) - total_ff);
      cnt_in     = CNT_W'(total_ff >> PEND_W);
      partial_in = value_ff[BYTE_BITS-1:0]
                   & ~({BYTE_BITS{1'b1}} << total_ff[PEND_W-1:0]);
      flush_byte = partial_ff << ((PEND_W + 1)'(BYTE_BITS) - {1'b0, pend_ff});
      flush_word = {flush_byte, {CODE_W{1'b0}}};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               priority if (req_command == CMD_ENCODE && sym_ok) begin
                  state_in = ST_LOOKUP;
               end else if (req_command == CMD_FLUSH && pend_ff != '0) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LOOKUP: state_in = ST_ALIGN;
         ST_ALIGN:  state_in = (cnt_in != '0) ? ST_EMIT : ST_IDLE;
         ST_EMIT: begin
            if (rsp_fire && cnt_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall       = (state_ff != ST_IDLE);
      rsp_valid       = (state_ff == ST_EMIT);
      rsp_out_byte    = word_ff[WORD_W-1 -: BYTE_BITS];
      rsp_last_of_run = (cnt_ff == CNT_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         partial_ff <= '0;
         pend_ff    <= '0;
         cnt_ff     <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_command == CMD_FLUSH) begin
                  cnt_ff     <= (pend_ff != '0) ? CNT_W'(1) : '0;
                  partial_ff <= '0;
                  pend_ff    <= '0;
               end
            end
            ST_LOOKUP: begin
            end
            ST_ALIGN: begin
               cnt_ff     <= cnt_in;
               partial_ff <= partial_in;
               pend_ff    <= total_ff[PEND_W-1:0];
            end
            ST_EMIT: begin
               if (rsp_fire) begin
                  cnt_ff <= cnt_ff - CNT_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_command == CMD_FLUSH) begin
               word_ff <= flush_word;
            end
         end
         ST_LOOKUP: begin
            value_ff <= value_in;
            total_ff <= total_in;
         end
         ST_ALIGN: word_ff <= word_in;
         ST_EMIT: begin
            if (rsp_fire) begin
               word_ff <= word_ff << BYTE_BITS;
            end
         end
         default: begin
         end
      endcase
   end

   `HCBP_ASSERT_IMP(a_emit_has_bytes, clock, reset, state_ff == ST_EMIT, cnt_ff != '0, "emit with no bytes left")
   `HCBP_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(MAX_BYTES), "byte count over max")
   `HCBP_ASSERT_IMP(a_partial_clean, clock, reset, 1'b1, (partial_ff >> pend_ff) == '0, "stale bits above pending")
   `HCBP_ASSERT_NXT(a_flush_clears, clock, reset, req_fire && req_command == CMD_FLUSH, pend_ff == '0, "flush left bits pending")
   `HCBP_ASSERT_NXT(a_more_beats, clock, reset, rsp_fire && cnt_ff != CNT_W'(1), state_ff == ST_EMIT, "byte run cut short")

endmodule

`default_nettype wire
